// ----- design/der_certificate_field_locator_top_macros.svh -----
// ----------------------------------------------------------------------------
// DER certificate field locator: assertion macros
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DER_CERTIFICATE_FIELD_LOCATOR_TOP_MACROS_SVH
`define DER_CERTIFICATE_FIELD_LOCATOR_TOP_MACROS_SVH

// Implication in the same cycle.
`define DCFL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle.
`define DCFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dcfl_pkg.sv -----
// ----------------------------------------------------------------------------
// DER certificate field locator package
// Result and queue entry types, status codes and field identifiers.
// ----------------------------------------------------------------------------
`default_nettype none

package dcfl_pkg;

  localparam logic [1:0] ST_FIELD = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  localparam logic [2:0] FID_NONE       = 3'd0;
  localparam logic [2:0] FID_SERIAL_HDR = 3'd0;
  localparam logic [2:0] FID_SERIAL     = 3'd1;
  localparam logic [2:0] FID_ISSUER_HDR = 3'd2;
  localparam logic [2:0] FID_VALIDITY   = 3'd3;
  localparam logic [2:0] FID_SUBJ_HDR   = 3'd4;
  localparam logic [2:0] FID_KEY_INFO   = 3'd5;

  localparam logic [7:0] LONG_FORM_BIT  = 8'h80;
  localparam logic [7:0] LEN_COUNT_MASK = 8'h7f;
  localparam logic [7:0] VERSION_MASK   = 8'ha0;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  field_id;
    logic [15:0] offset;
    logic [15:0] length;
  } dcfl_res_t;

  // One queue entry carries every result that a single byte causes.
  typedef struct packed {
    logic      two;
    dcfl_res_t res0;
    dcfl_res_t res1;
  } dcfl_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dcfl_q_status_t;

endpackage

`default_nettype wire

// ----- design/dcfl_front.sv -----
// ----------------------------------------------------------------------------
// DER certificate field locator: front end
// Walks the tag-length headers byte by byte and builds result entries.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfl_front
  import dcfl_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first,
  input  wire logic [15:0] in_total_length,
  output logic             push,
  output dcfl_entry_t      push_entry
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_CERT, PH_TBS, PH_FIRST, PH_VERSION, PH_SERIAL, PH_ALG,
    PH_ISSUER, PH_VALID, PH_SUBJECT, PH_KEY, PH_DONE, PH_FAIL
  } phase_t;

  localparam logic [1:0] HS_TAG  = 2'd0;
  localparam logic [1:0] HS_LEN  = 2'd1;
  localparam logic [1:0] HS_LONG = 2'd2;

  phase_t              phase_r, phase_nxt;
  logic [1:0]          hstep_r, hstep_nxt;
  logic [6:0]          lbl_r, lbl_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [7:0]          hbytes_r, hbytes_nxt;
  logic [LEN_BITS-1:0] hstart_r, hstart_nxt;
  logic [LEN_BITS-1:0] bpos_r, bpos_nxt;
  logic [LEN_BITS-1:0] rtot_r, rtot_nxt;
  logic [LEN_BITS-1:0] rcert_r, rcert_nxt;
  logic [LEN_BITS-1:0] rtbs_r, rtbs_nxt;
  logic [LEN_BITS-1:0] skip_r, skip_nxt;

  always_comb begin
    logic                active;
    logic                hdr_done;
    logic                hdr_fail;
    logic [LEN_BITS-1:0] rem;
    logic [LEN_BITS-1:0] coff;
    logic [15:0]         len_hdr;

    phase_nxt  = phase_r;
    hstep_nxt  = hstep_r;
    lbl_nxt    = lbl_r;
    acc_nxt    = acc_r;
    hbytes_nxt = hbytes_r;
    hstart_nxt = hstart_r;
    bpos_nxt   = bpos_r;
    rtot_nxt   = rtot_r;
    rcert_nxt  = rcert_r;
    rtbs_nxt   = rtbs_r;
    skip_nxt   = skip_r;
    push       = 1'b0;
    push_entry = '0;
    active     = 1'b0;
    hdr_done   = 1'b0;
    hdr_fail   = 1'b0;
    rem        = '0;
    coff       = '0;
    len_hdr    = '0;

    if (in_fire) begin
      if (in_first) begin
        phase_nxt  = PH_CERT;
        hstep_nxt  = HS_TAG;
        lbl_nxt    = '0;
        acc_nxt    = '0;
        hbytes_nxt = '0;
        hstart_nxt = '0;
        bpos_nxt   = '0;
        rtot_nxt   = LEN_BITS'(in_total_length);
        rcert_nxt  = '0;
        rtbs_nxt   = '0;
        skip_nxt   = '0;
        active     = 1'b1;
      end else begin
        active = !(phase_r == PH_IDLE || phase_r == PH_DONE || phase_r == PH_FAIL);
      end

      if (active) begin
        if (phase_nxt != PH_CERT && phase_nxt != PH_TBS && skip_nxt != '0 &&
            hstep_nxt == HS_TAG) begin
          // Passing over the content of an element that is not reported.
          skip_nxt = skip_nxt - LEN_BITS'(1);
          rtbs_nxt = rtbs_nxt - LEN_BITS'(1);
        end else begin
          if (phase_nxt == PH_FIRST) begin
            phase_nxt = ((in_data_byte & VERSION_MASK) == VERSION_MASK) ? PH_VERSION
                                                                        : PH_SERIAL;
          end
          case (phase_nxt)
            PH_CERT: rem = rtot_nxt;
            PH_TBS:  rem = rcert_nxt;
            default: rem = rtbs_nxt;
          endcase

          if (rem == '0) begin
            hdr_fail = 1'b1;
          end else begin
            rem = rem - LEN_BITS'(1);
            if (hstep_nxt == HS_TAG) begin
              if (in_data_byte == 8'h00) begin
                hdr_fail = 1'b1;
              end else begin
                hstart_nxt = bpos_nxt;
                hbytes_nxt = 8'd1;
                hstep_nxt  = HS_LEN;
              end
            end else begin
              hbytes_nxt = hbytes_nxt + 8'd1;
              if (hstep_nxt == HS_LEN) begin
                if ((in_data_byte & LONG_FORM_BIT) != 8'h00) begin
                  lbl_nxt = 7'(in_data_byte & LEN_COUNT_MASK);
                  acc_nxt = '0;
                  if (lbl_nxt != 7'd0) begin
                    hstep_nxt = HS_LONG;
                  end else begin
                    hdr_done = 1'b1;
                  end
                end else begin
                  acc_nxt  = {24'h000000, in_data_byte};
                  hdr_done = 1'b1;
                end
              end else begin
                acc_nxt = {acc_nxt[23:0], in_data_byte};
                lbl_nxt = lbl_nxt - 7'd1;
                if (lbl_nxt == 7'd0) begin
                  hdr_done = 1'b1;
                end
              end
            end
            if (hdr_done) begin
              hstep_nxt = HS_TAG;
              if (acc_nxt > 32'(rem)) begin
                hdr_fail = 1'b1;
                hdr_done = 1'b0;
              end
            end
          end

          case (phase_nxt)
            PH_CERT: rtot_nxt  = rem;
            PH_TBS:  rcert_nxt = rem;
            default: rtbs_nxt  = rem;
          endcase

          if (hdr_done) begin
            coff    = hstart_nxt + LEN_BITS'(hbytes_nxt);
            len_hdr = acc_nxt[15:0] + {8'h00, hbytes_nxt};
            unique case (phase_nxt)
              PH_CERT: begin
                rcert_nxt = LEN_BITS'(acc_nxt);
                phase_nxt = PH_TBS;
              end
              PH_TBS: begin
                rtbs_nxt  = LEN_BITS'(acc_nxt);
                phase_nxt = PH_FIRST;
              end
              PH_VERSION: begin
                skip_nxt  = LEN_BITS'(acc_nxt);
                phase_nxt = PH_SERIAL;
              end
              PH_SERIAL: begin
                skip_nxt   = LEN_BITS'(acc_nxt);
                push       = 1'b1;
                push_entry.two  = 1'b1;
                push_entry.res0 = '{ST_FIELD, FID_SERIAL_HDR, 16'(hstart_nxt), len_hdr};
                push_entry.res1 = '{ST_FIELD, FID_SERIAL, 16'(coff), acc_nxt[15:0]};
                phase_nxt  = PH_ALG;
              end
              PH_ALG: begin
                skip_nxt  = LEN_BITS'(acc_nxt);
                phase_nxt = PH_ISSUER;
              end
              PH_ISSUER: begin
                skip_nxt   = LEN_BITS'(acc_nxt);
                push       = 1'b1;
                push_entry.res0 = '{ST_FIELD, FID_ISSUER_HDR, 16'(hstart_nxt), len_hdr};
                phase_nxt  = PH_VALID;
              end
              PH_VALID: begin
                skip_nxt   = LEN_BITS'(acc_nxt);
                push       = 1'b1;
                push_entry.res0 = '{ST_FIELD, FID_VALIDITY, 16'(coff), acc_nxt[15:0]};
                phase_nxt  = PH_SUBJECT;
              end
              PH_SUBJECT: begin
                skip_nxt   = LEN_BITS'(acc_nxt);
                push       = 1'b1;
                push_entry.res0 = '{ST_FIELD, FID_SUBJ_HDR, 16'(hstart_nxt), len_hdr};
                phase_nxt  = PH_KEY;
              end
              PH_KEY: begin
                skip_nxt   = LEN_BITS'(acc_nxt);
                push       = 1'b1;
                push_entry.two  = 1'b1;
                push_entry.res0 = '{ST_FIELD, FID_KEY_INFO, 16'(coff), acc_nxt[15:0]};
                push_entry.res1 = '{ST_DONE, FID_NONE, 16'h0000, 16'h0000};
                phase_nxt  = PH_DONE;
              end
              default: begin
                phase_nxt = PH_FAIL;
              end
            endcase
          end
        end

        if (hdr_fail) begin
          push       = 1'b1;
          push_entry = '0;
          push_entry.res0 = '{ST_FAIL, FID_NONE, 16'(bpos_nxt), 16'h0000};
          phase_nxt  = PH_FAIL;
        end
        bpos_nxt = bpos_nxt + LEN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hstep_r  <= HS_TAG;
      lbl_r    <= '0;
      acc_r    <= '0;
      hbytes_r <= '0;
      hstart_r <= '0;
      bpos_r   <= '0;
      rtot_r   <= '0;
      rcert_r  <= '0;
      rtbs_r   <= '0;
      skip_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      hstep_r  <= hstep_nxt;
      lbl_r    <= lbl_nxt;
      acc_r    <= acc_nxt;
      hbytes_r <= hbytes_nxt;
      hstart_r <= hstart_nxt;
      bpos_r   <= bpos_nxt;
      rtot_r   <= rtot_nxt;
      rcert_r  <= rcert_nxt;
      rtbs_r   <= rtbs_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/dcfl_queue.sv -----
// ----------------------------------------------------------------------------
// DER certificate field locator: entry queue
// Small first-in first-out register queue between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfl_queue
  import dcfl_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  dcfl_entry_t   push_entry,
  input  wire logic     pop,
  output dcfl_entry_t   head,
  output dcfl_q_status_t status
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  dcfl_entry_t      slot_r [DEPTH];
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + IDX_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + IDX_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/dcfl_back.sv -----
// ----------------------------------------------------------------------------
// DER certificate field locator: back end
// Unpacks queue entries into single results held in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcfl_back
  import dcfl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  dcfl_entry_t     head,
  input  dcfl_q_status_t  q_status,
  output logic            pop,
  input  wire logic       out_stall,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [2:0]      out_field_id,
  output logic [15:0]     out_field_offset,
  output logic [15:0]     out_field_length,
  output logic            out_last_of_run
);

  logic      valid_r, valid_nxt;
  logic      half_r, half_nxt;
  dcfl_res_t res_r, res_nxt;
  logic      last_r, last_nxt;
  logic      load;

  // The output register may take a new result when empty or being drained.
  assign load = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    res_nxt   = res_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = !q_status.empty;
      if (!q_status.empty) begin
        if (head.two && !half_r) begin
          res_nxt  = head.res0;
          last_nxt = 1'b0;
          half_nxt = 1'b1;
        end else begin
          res_nxt  = half_r ? head.res1 : head.res0;
          last_nxt = 1'b1;
          half_nxt = 1'b0;
          pop      = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_status       = res_r.status;
  assign out_field_id     = res_r.field_id;
  assign out_field_offset = res_r.offset;
  assign out_field_length = res_r.length;
  assign out_last_of_run  = last_r;

endmodule

`default_nettype wire

// ----- design/der_certificate_field_locator_top.sv -----
// ----------------------------------------------------------------------------
// DER certificate field locator, top level
// A byte's results are written into the entry queue, then into the output register.
// Throughput: one byte per cycle when not stalled; a byte's results leave in turn.
// The input stalls only while the QUEUE_DEPTH entry queue is full.
// Reset (rst_n low, synchronous) idles the parser and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "der_certificate_field_locator_top_macros.svh"

module der_certificate_field_locator_top
  import dcfl_pkg::*;
#(
  parameter int LEN_BITS    = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first,
  input  wire logic [15:0] in_total_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [2:0]       out_field_id,
  output logic [15:0]      out_field_offset,
  output logic [15:0]      out_field_length,
  output logic             out_last_of_run
);

  // The front end decodes every byte in the cycle of its transfer and, when
  // the byte completes a reported header or fails the parse, writes one
  // entry holding all of that byte's results into the queue. Bytes that
  // cause no result leave the queue untouched, so long runs of skipped
  // content flow at full rate during output stalls until the queue is full.
  // The back end reads the head entry and presents its results one at a
  // time from a registered output stage.

  logic           in_fire;
  logic           push;
  logic           pop;
  dcfl_entry_t    push_entry;
  dcfl_entry_t    head;
  dcfl_q_status_t q_status;

  // Stall is taken from the registered queue fill only, never from in_valid.
  assign in_stall = q_status.full;
  assign in_fire  = in_valid && !in_stall;

  dcfl_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (in_fire),
    .in_data_byte    (in_data_byte),
    .in_first        (in_first),
    .in_total_length (in_total_length),
    .push            (push),
    .push_entry      (push_entry)
  );

  dcfl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  dcfl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_status         (q_status),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_field_id     (out_field_id),
    .out_field_offset (out_field_offset),
    .out_field_length (out_field_length),
    .out_last_of_run  (out_last_of_run)
  );

  // A write into a full queue would overwrite an entry not yet delivered.
  `DCFL_ASSERT_SAME(a_no_push_when_full, push, !q_status.full, "queue written while full")

  // Completion and failure are always the final result of their byte.
  `DCFL_ASSERT_SAME(a_end_is_last,
    out_valid && (out_status == ST_DONE || out_status == ST_FAIL), out_last_of_run,
    "completion or failure result not marked last")

  // The serial with header is always followed by the serial content.
  `DCFL_ASSERT_SAME(a_serial_hdr_not_last,
    out_valid && out_status == ST_FIELD && out_field_id == FID_SERIAL_HDR,
    !out_last_of_run, "serial with header marked last")

  // The second result of a byte follows its first without a gap.
  `DCFL_ASSERT_NEXT(a_second_follows,
    out_valid && !out_stall && !out_last_of_run,
    out_valid && out_last_of_run, "second result of a byte did not follow")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// DER certificate field locator testbench
// Streams certificate bytes into the locator with random gaps and output
// stalls. Each accepted byte goes through a parser model kept here, and every
// result that comes out is compared field by field with the oldest report
// the model is waiting on. Hand-built encodings cover the corner cases and
// randomly generated certificates, some of them damaged, cover the rest.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcfl_pkg::*;

  // Tags used when building encodings by hand. Any non-zero tag is accepted
  // by the block, but the serial must not look like the optional version.
  localparam logic [7:0] SEQUENCE_TAG = 8'h30;
  localparam logic [7:0] INTEGER_TAG  = 8'h02;

  // The watchdog gives up after this many cycles without a single transfer
  // on either channel. Gaps and stalls always end on their own, so a
  // healthy run never comes near it.
  localparam int STALL_LIMIT = 1000;

  // Cycles to wait after the last expected report before deciding the run.
  localparam int SETTLE_CYCLES = 10;

  typedef logic [7:0] byte_q_t[$];

  // Phases of the parser, in the order in which a certificate is walked.
  typedef enum logic [3:0] {
    PH_IDLE, PH_CERT, PH_TBS, PH_FIRST, PH_VERSION, PH_SERIAL, PH_ALG,
    PH_ISSUER, PH_VALID, PH_SUBJECT, PH_KEY, PH_DONE, PH_FAIL
  } parse_phase_t;

  // Outcome of one header byte.
  typedef enum int {HDR_FAIL, HDR_MORE, HDR_DONE} header_result_t;

  // One report from the block, as the model predicts it.
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  field_id;
    logic [15:0] offset;
    logic [15:0] length;
    logic        last;
  } field_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_first = 1'b0;
  logic [15:0] in_total_length = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [2:0]  out_field_id;
  logic [15:0] out_field_offset;
  logic [15:0] out_field_length;
  logic        out_last_of_run;

  der_certificate_field_locator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_first         (in_first),
    .in_total_length  (in_total_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_field_id     (out_field_id),
    .out_field_offset (out_field_offset),
    .out_field_length (out_field_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Reports predicted but not yet seen on the output, oldest first.
  field_report_t pending_fields[$];
  int            mismatch_count = 0;
  int            bytes_sent = 0;
  // Random gaps on the input and stalls on the output are only inserted
  // while this is set; the closing stretch of the run clears it.
  bit            idling_on = 1'b1;

  // --------------------------------------------------------------------------
  // Parser model. It keeps its own copy of the walker state, and each
  // accepted byte moves it on and may queue up to two reports.
  // --------------------------------------------------------------------------
  parse_phase_t pr_phase;
  logic [1:0]   hdr_step;      // 0 tag, 1 first length byte, 2 long-form bytes
  logic [6:0]   len_left;      // long-form length bytes still to come
  logic [31:0]  len_accum;
  logic [7:0]   hdr_count;     // bytes of the header seen so far
  logic [15:0]  hdr_start;
  logic [15:0]  byte_pos;
  logic [15:0]  left_total;    // bytes left for the outer element
  logic [15:0]  left_cert;     // content left inside the certificate
  logic [15:0]  left_tbs;      // content left inside the tbsCertificate
  logic [15:0]  skip_left;     // content bytes still to pass over

  function automatic void reset_parser();
    pr_phase   = PH_IDLE;
    hdr_step   = 2'd0;
    len_left   = 7'd0;
    len_accum  = 32'd0;
    hdr_count  = 8'd0;
    hdr_start  = 16'd0;
    byte_pos   = 16'd0;
    left_total = 16'd0;
    left_cert  = 16'd0;
    left_tbs   = 16'd0;
    skip_left  = 16'd0;
  endfunction

  // One byte of a tag-length header at a level that has 'left' bytes to go.
  // The length check is made against what remains once the header is done.
  function automatic header_result_t parse_header_byte(input logic [7:0] b,
                                                       inout logic [15:0] left);
    if (left == 16'd0) return HDR_FAIL;
    left = left - 16'd1;
    if (hdr_step == 2'd0) begin
      if (b == 8'h00) return HDR_FAIL;
      hdr_start = byte_pos;
      hdr_count = 8'd1;
      hdr_step  = 2'd1;
      return HDR_MORE;
    end
    hdr_count = hdr_count + 8'd1;
    if (hdr_step == 2'd1) begin
      if ((b & LONG_FORM_BIT) != 8'h00) begin
        len_left  = 7'(b & LEN_COUNT_MASK);
        len_accum = 32'd0;
        if (len_left != 7'd0) begin
          hdr_step = 2'd2;
          return HDR_MORE;
        end
      end else begin
        len_accum = {24'd0, b};
      end
    end else begin
      // Long-form bytes shift into a 32-bit value that simply wraps.
      len_accum = {len_accum[23:0], b};
      len_left  = len_left - 7'd1;
      if (len_left != 7'd0) return HDR_MORE;
    end
    hdr_step = 2'd0;
    if (len_accum > {16'd0, left}) return HDR_FAIL;
    return HDR_DONE;
  endfunction

  function automatic field_report_t make_report(input logic [1:0] st, input logic [2:0] id,
                                                input logic [15:0] off,
                                                input logic [15:0] len);
    field_report_t rep;
    rep.status   = st;
    rep.field_id = id;
    rep.offset   = off;
    rep.length   = len;
    rep.last     = 1'b0;
    return rep;
  endfunction

  // Moves the model on by one accepted byte and queues what it should cause.
  function automatic void locate_fields(input logic [7:0] b, input logic f,
                                        input logic [15:0] tl);
    field_report_t  found[2];
    int             n;
    header_result_t r;
    logic [15:0]    content_off;
    logic [15:0]    with_hdr;
    n = 0;
    r = HDR_MORE;
    if (f) begin
      reset_parser();
      left_total = tl;
      pr_phase   = PH_CERT;
    end else if (pr_phase == PH_IDLE || pr_phase == PH_DONE || pr_phase == PH_FAIL) begin
      // The stream is ignored until the next first byte.
      return;
    end

    if (pr_phase == PH_CERT) begin
      r = parse_header_byte(b, left_total);
      if (r == HDR_DONE) begin
        left_cert = len_accum[15:0];
        pr_phase  = PH_TBS;
      end
    end else if (pr_phase == PH_TBS) begin
      r = parse_header_byte(b, left_cert);
      if (r == HDR_DONE) begin
        left_tbs = len_accum[15:0];
        pr_phase = PH_FIRST;
      end
    end else if (skip_left != 16'd0 && hdr_step == 2'd0) begin
      skip_left = skip_left - 16'd1;
      left_tbs  = left_tbs - 16'd1;
    end else begin
      if (pr_phase == PH_FIRST)
        pr_phase = ((b & VERSION_MASK) == VERSION_MASK) ? PH_VERSION : PH_SERIAL;
      r = parse_header_byte(b, left_tbs);
      if (r == HDR_DONE) begin
        content_off = hdr_start + {8'd0, hdr_count};
        with_hdr    = len_accum[15:0] + {8'd0, hdr_count};
        skip_left   = len_accum[15:0];
        case (pr_phase)
          PH_SERIAL: begin
            found[0] = make_report(ST_FIELD, FID_SERIAL_HDR, hdr_start, with_hdr);
            found[1] = make_report(ST_FIELD, FID_SERIAL, content_off, len_accum[15:0]);
            n = 2;
          end
          PH_ISSUER: begin
            found[0] = make_report(ST_FIELD, FID_ISSUER_HDR, hdr_start, with_hdr);
            n = 1;
          end
          PH_VALID: begin
            found[0] = make_report(ST_FIELD, FID_VALIDITY, content_off, len_accum[15:0]);
            n = 1;
          end
          PH_SUBJECT: begin
            found[0] = make_report(ST_FIELD, FID_SUBJ_HDR, hdr_start, with_hdr);
            n = 1;
          end
          PH_KEY: begin
            found[0] = make_report(ST_FIELD, FID_KEY_INFO, content_off, len_accum[15:0]);
            found[1] = make_report(ST_DONE, FID_NONE, 16'd0, 16'd0);
            n = 2;
          end
          default: begin
          end
        endcase
        if (pr_phase == PH_VERSION)  pr_phase = PH_SERIAL;
        else if (pr_phase == PH_KEY) pr_phase = PH_DONE;
        else                         pr_phase = parse_phase_t'(pr_phase + 4'd1);
      end
    end

    if (r == HDR_FAIL) begin
      found[n] = make_report(ST_FAIL, FID_NONE, byte_pos, 16'd0);
      n++;
      pr_phase = PH_FAIL;
    end
    byte_pos = byte_pos + 16'd1;
    for (int i = 0; i < n; i++) begin
      found[i].last = (i == n - 1);
      pending_fields = {pending_fields, found[i]};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Certificate builders.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] random_tag();
    return 8'($urandom_range(1, 255));
  endfunction

  // Tag and length bytes, with the length form picked at random: short form,
  // the zero-count long form for empty content, or long form with up to two
  // redundant leading zero bytes.
  function automatic byte_q_t tlv_header(input logic [7:0] tag, input int unsigned len);
    byte_q_t     h;
    int unsigned nbytes;
    int unsigned pad;
    h = {};
    h = {h, tag};
    if (len == 0 && $urandom_range(0, 3) == 0) begin
      h = {h, LONG_FORM_BIT};
    end else if (len < 128 && $urandom_range(0, 2) != 0) begin
      h = {h, 8'(len)};
    end else begin
      nbytes = (len > 255) ? 2 : 1;
      pad    = $urandom_range(0, 2);
      h = {h, LONG_FORM_BIT | 8'(nbytes + pad)};
      repeat (pad) h = {h, 8'h00};
      for (int i = int'(nbytes) - 1; i >= 0; i--) h = {h, 8'(len >> (8 * i))};
    end
    return h;
  endfunction

  function automatic byte_q_t tlv_element(input logic [7:0] tag, input int unsigned len);
    byte_q_t e;
    e = tlv_header(tag, len);
    repeat (len) e = {e, 8'($urandom)};
    return e;
  endfunction

  // A well-formed certificate with random content. Contents are kept short
  // so that many certificates, and so many reports, fit into the run; a long
  // algorithm element now and then pushes the offsets into their upper bits.
  function automatic byte_q_t random_certificate(input int unsigned max_len,
                                                 input bit long_skip);
    byte_q_t tbs;
    byte_q_t sig;
    tbs = {};
    if ($urandom_range(0, 1) == 0)
      tbs = {tbs, tlv_element(VERSION_MASK | 8'($urandom), $urandom_range(0, 3))};
    tbs = {tbs, tlv_element(INTEGER_TAG, $urandom_range(1, max_len))};
    tbs = {tbs, tlv_element(random_tag(),
                            long_skip ? $urandom_range(256, 1500) : $urandom_range(0, max_len))};
    tbs = {tbs, tlv_element(random_tag(), $urandom_range(0, max_len))};
    tbs = {tbs, tlv_element(random_tag(), $urandom_range(0, max_len))};
    tbs = {tbs, tlv_element(random_tag(), $urandom_range(0, max_len))};
    tbs = {tbs, tlv_element(random_tag(), $urandom_range(0, max_len))};
    tbs = {tlv_header(random_tag(), tbs.size()), tbs};
    sig = tlv_element(random_tag(), $urandom_range(0, 2));
    return {tlv_header(random_tag(), tbs.size() + sig.size()), tbs, sig};
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Every task here is entered and left at a falling edge, with
  // in_valid possibly still high so that back-to-back transfers run without
  // a gap. Anything that waits drops in_valid first.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic f, input logic [15:0] tl);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_first        <= f;
    in_total_length <= tl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The transfer has happened at this edge; the model follows it.
    locate_fields(b, f, tl);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends the first 'count' bytes of a certificate. Only the first byte
  // carries the total length that matters; the others carry random values
  // in that field, which the block must not look at.
  task automatic send_certificate(input byte_q_t c, input logic [15:0] tl, input int count);
    for (int i = 0; i < count && i < c.size(); i++)
      send_byte(c[i], i == 0, (i == 0) ? tl : 16'($urandom));
  endtask

  // Holds the input quiet until every predicted report has been seen.
  task automatic await_all_fields();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_fields.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Straight after reset the parser is idle, so bytes without first set must
  // be dropped without any report.
  task automatic test_idle_stream();
    send_byte(8'h00, 1'b0, 16'h0000);
    send_byte(8'hff, 1'b0, 16'hffff);
    send_byte(SEQUENCE_TAG, 1'b0, 16'h0010);
    await_all_fields();
  endtask

  // A hand-built certificate that walks every field. It has a version, a
  // serial whose five-byte long-form length wraps round to three, an
  // algorithm element with the zero-count long form, a one-byte long form on
  // the issuer, an empty subject, and key content that is trailing data the
  // block ignores. One more byte after it must be ignored as well.
  task automatic test_fixed_certificate();
    byte_q_t c;
    c = {8'h30, 8'h25,
         8'h30, 8'h23,
         8'ha0, 8'h03, 8'h02, 8'h01, 8'h02,
         8'h02, 8'h85, 8'h01, 8'h00, 8'h00, 8'h00, 8'h03, 8'haa, 8'hbb, 8'hcc,
         8'h30, 8'h80,
         8'h30, 8'h81, 8'h02, 8'h31, 8'h00,
         8'h30, 8'h04, 8'haa, 8'hbb, 8'hcc, 8'hdd,
         8'h30, 8'h00,
         8'h30, 8'h03, 8'h01, 8'h02, 8'h03};
    send_certificate(c, 16'(c.size()), c.size());
    send_byte(8'h30, 1'b0, 16'h0000);
    await_all_fields();
  endtask

  // Failure paths: a zero tag, a header that runs past the bytes left at its
  // level, and a length larger than what remains. After a failure the
  // stream is ignored until the next first byte.
  task automatic test_failures();
    send_byte(8'h00, 1'b1, 16'd10);
    send_byte(8'h30, 1'b1, 16'd1);
    send_byte(8'h05, 1'b0, 16'd0);
    send_byte(8'h11, 1'b0, 16'd0);
    send_byte(SEQUENCE_TAG, 1'b1, 16'd4);
    send_byte(8'h10, 1'b0, 16'd0);
    await_all_fields();
  endtask

  // Extreme field values: the largest total length with all-ones bytes, and
  // a zero total length, where even the tag byte has no room.
  task automatic test_field_extremes();
    send_byte(8'hff, 1'b1, 16'hffff);
    send_byte(8'h81, 1'b0, 16'h0000);
    send_byte(8'hff, 1'b0, 16'hffff);
    send_byte(8'h00, 1'b1, 16'h0000);
    await_all_fields();
  endtask

  // The sender waits for the output to run dry before every byte, so each
  // report leaves an otherwise empty pipeline.
  task automatic test_pressure_pause();
    byte_q_t c;
    c = random_certificate(3, 1'b0);
    for (int i = 0; i < c.size(); i++) begin
      send_byte(c[i], i == 0, (i == 0) ? 16'(c.size()) : 16'($urandom));
      await_all_fields();
    end
  endtask

  // The bulk of the run. Most items are well-formed certificates with random
  // content, since only those reach the later fields. The rest are damaged
  // certificates (a corrupted byte, a total length that is too short, or a
  // stream cut off and restarted) and bursts of noise. Gaps and stalls stop
  // for the final stretch.
  task automatic test_random_certificates();
    byte_q_t     c;
    int          start;
    int unsigned pick;
    int          idx;
    int          count;
    start = bytes_sent;
    while (bytes_sent - start < 1000) begin
      if (bytes_sent - start > 850) idling_on = 1'b0;
      pick = $urandom_range(0, 99);
      c = random_certificate(4, $urandom_range(0, 39) == 0);
      if (pick < 65) begin
        send_certificate(c, 16'(c.size() + $urandom_range(0, 3)), c.size());
      end else if (pick < 75) begin
        idx = $urandom_range(0, c.size() - 1);
        c[idx] = 8'($urandom);
        send_certificate(c, 16'(c.size()), c.size());
      end else if (pick < 82) begin
        send_certificate(c, 16'($urandom_range(0, c.size() - 1)), c.size());
      end else if (pick < 89) begin
        send_certificate(c, 16'(c.size()), $urandom_range(1, c.size()));
      end else if (pick < 96) begin
        count = $urandom_range(1, 12);
        repeat (count)
          send_byte(8'($urandom), $urandom_range(0, 7) == 0, 16'($urandom));
      end else begin
        await_all_fields();
        send_certificate(c, 16'(c.size()), c.size());
      end
    end
  endtask

  // Lets the last reports arrive, gives the block a few more cycles in which
  // nothing may appear, and then decides the run.
  task automatic finish_run();
    await_all_fields();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  endtask

  initial begin
    reset_parser();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_stream();
    test_fixed_certificate();
    test_failures();
    test_field_extremes();
    test_pressure_pause();
    test_random_certificates();
    finish_run();
  end

  // --------------------------------------------------------------------------
  // Output side. Stalls come in bursts of random length and change
  // only at the falling edge.
  // --------------------------------------------------------------------------
  int stall_more = 0;

  always @(negedge clk) begin
    if (stall_more != 0) begin
      out_stall  <= 1'b1;
      stall_more = stall_more - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_more = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Every result transfer is matched against the oldest predicted report.
  always @(posedge clk) begin
    field_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_fields.size() == 0) begin
        $display("%0t: unexpected result, status %0d id %0d offset %0d length %0d",
                 $time, out_status, out_field_id, out_field_offset, out_field_length);
        mismatch_count++;
      end else begin
        want = pending_fields.pop_front();
        compare_field("status", 16'(want.status), 16'(out_status));
        compare_field("field_id", 16'(want.field_id), 16'(out_field_id));
        compare_field("field_offset", want.offset, out_field_offset);
        compare_field("field_length", want.length, out_field_length);
        compare_field("last_of_run", 16'(want.last), 16'(out_last_of_run));
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no transfer for %0d cycles, %0d reports outstanding",
                   $time, quiet_cycles, pending_fields.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/dcfl_pkg.sv
design/dcfl_front.sv
design/dcfl_queue.sv
design/dcfl_back.sv
design/der_certificate_field_locator_top.sv
verif/tb_top.sv
